FILE: src/ppa_pkg.sv
`timescale 1ns / 1ps
package ppa_pkg;

   localparam int COORD_W     = 16;
   localparam int SQUARE_W    = 32;
   localparam int RADICAND_W  = 34;
   localparam int ROOT_W      = 17;
   localparam int REM_W       = 19;
   localparam int ROOT_ITERS  = RADICAND_W / 2;
   localparam int ITER_W      = 5;
   localparam int SUM_W       = 32;
   localparam int SCALE_W     = 16;
   localparam int SCALE_SUM_W = SCALE_W + 1;
   localparam int PERIM_W     = 48;
   localparam int PROD_W      = PERIM_W + 1;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd2560;

   typedef enum logic {
      CSR_SCALE_X = 1'b0,
      CSR_SCALE_Y = 1'b1
   } csr_index_type;

   // One accepted vertex as seen by the back end: the edge from the previous
   // vertex (when there is one) and the closing edge back to the first vertex.
   typedef struct packed {
      logic               edge_valid;
      logic [COORD_W-1:0] edge_dx;
      logic [COORD_W-1:0] edge_dy;
      logic               last;
      logic [COORD_W-1:0] close_dx;
      logic [COORD_W-1:0] close_dy;
   } edge_job_type;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] diff;
      logic [COORD_W:0] mag;
      diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      mag  = diff[COORD_W] ? (~diff + {{COORD_W{1'b0}}, 1'b1}) : diff;
      return mag[COORD_W-1:0];
   endfunction

endpackage

FILE: src/ppa_if.sv
`timescale 1ns / 1ps
interface ppa_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ppa_pkg::COORD_W-1:0]  vertex_x;
   logic signed [ppa_pkg::COORD_W-1:0]  vertex_y;
   logic                                last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);
endinterface

interface ppa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ppa_pkg::PERIM_W-1:0]   perimeter;
   logic                          saturated;

   modport source (output valid, output perimeter, output saturated, input ready);
   modport sink   (input valid, input perimeter, input saturated, output ready);
endinterface

FILE: src/ppa_front.sv
`timescale 1ns / 1ps
module ppa_front (
   input  logic                  clock,
   input  logic                  reset,
   ppa_req_if.sink               req_bus,
   output logic                  push_valid,
   output ppa_pkg::edge_job_type push_job,
   input  logic                  push_ready
);

   logic                         have_first_ff;
   logic [ppa_pkg::COORD_W-1:0]  first_x_ff;
   logic [ppa_pkg::COORD_W-1:0]  first_y_ff;
   logic [ppa_pkg::COORD_W-1:0]  prev_x_ff;
   logic [ppa_pkg::COORD_W-1:0]  prev_y_ff;
   logic [ppa_pkg::COORD_W-1:0]  vx;
   logic [ppa_pkg::COORD_W-1:0]  vy;
   logic [ppa_pkg::COORD_W-1:0]  anchor_x;
   logic [ppa_pkg::COORD_W-1:0]  anchor_y;
   logic                         accept;

   assign vx       = req_bus.vertex_x;
   assign vy       = req_bus.vertex_y;
   assign accept   = req_bus.valid && push_ready;
   assign req_bus.ready = push_ready;

   // A vertex that opens a polygon is its own anchor: closing edge of zero.
   assign anchor_x = have_first_ff ? first_x_ff : vx;
   assign anchor_y = have_first_ff ? first_y_ff : vy;

   always_comb begin
      push_valid          = req_bus.valid;
      push_job.edge_valid = have_first_ff;
      push_job.edge_dx    = ppa_pkg::abs_diff(vx, prev_x_ff);
      push_job.edge_dy    = ppa_pkg::abs_diff(vy, prev_y_ff);
      push_job.last       = req_bus.last_vertex;
      push_job.close_dx   = ppa_pkg::abs_diff(anchor_x, vx);
      push_job.close_dy   = ppa_pkg::abs_diff(anchor_y, vy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
      end else if (accept) begin
         have_first_ff <= !req_bus.last_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_x_ff <= vx;
         prev_y_ff <= vy;
         if (!have_first_ff) begin
            first_x_ff <= vx;
            first_y_ff <= vy;
         end
      end
   end

endmodule

FILE: src/ppa_fifo.sv
`timescale 1ns / 1ps
module ppa_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  ppa_pkg::edge_job_type push_job,
   output logic                  push_ready,
   output logic                  pop_valid,
   output ppa_pkg::edge_job_type pop_job,
   input  logic                  pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ppa_pkg::edge_job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: src/ppa_back.sv
`timescale 1ns / 1ps
module ppa_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   input  ppa_pkg::edge_job_type        pop_job,
   output logic                         pop_ready,
   input  logic [ppa_pkg::SCALE_W-1:0]  scale_x,
   input  logic [ppa_pkg::SCALE_W-1:0]  scale_y,
   ppa_rsp_if.source                    rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_LOAD,
      ST_ROOT,
      ST_ACCUM,
      ST_MULT,
      ST_EMIT
   } state_type;

   state_type                         state_ff;
   logic                              last_ff;
   logic                              closing_ff;
   logic [ppa_pkg::COORD_W-1:0]       dx_ff;
   logic [ppa_pkg::COORD_W-1:0]       dy_ff;
   logic [ppa_pkg::COORD_W-1:0]       close_dx_ff;
   logic [ppa_pkg::COORD_W-1:0]       close_dy_ff;
   logic [ppa_pkg::SQUARE_W-1:0]      sqx_ff;
   logic [ppa_pkg::SQUARE_W-1:0]      sqy_ff;
   logic [ppa_pkg::RADICAND_W-1:0]    rad_ff;
   logic [ppa_pkg::REM_W-1:0]         rem_ff;
   logic [ppa_pkg::ROOT_W-1:0]        root_ff;
   logic [ppa_pkg::ITER_W-1:0]        iter_ff;
   logic [ppa_pkg::SUM_W-1:0]         sum_ff;
   logic [ppa_pkg::PROD_W-1:0]        prod_ff;
   logic                              out_valid_ff;
   logic [ppa_pkg::PERIM_W-1:0]       perim_ff;
   logic                              sat_ff;

   logic [ppa_pkg::REM_W+1:0]         rem_shift;
   logic [ppa_pkg::REM_W+1:0]         root_trial;
   logic [ppa_pkg::REM_W+1:0]         rem_diff;
   logic                              root_ge;
   logic [ppa_pkg::SUM_W:0]           sum_next;
   logic [ppa_pkg::SCALE_SUM_W-1:0]   scale_sum;
   logic                              out_free;

   assign pop_ready         = (state_ff == ST_IDLE);
   assign out_free          = !out_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.perimeter = perim_ff;
   assign rsp_bus.saturated = sat_ff;

   // One root digit per cycle: bring down two radicand bits, try 4*root+1.
   always_comb begin
      rem_shift  = {rem_ff, rad_ff[ppa_pkg::RADICAND_W-1 -: 2]};
      root_trial = {2'b00, root_ff, 2'b01};
      root_ge    = (rem_shift >= root_trial);
      rem_diff   = rem_shift - root_trial;
      sum_next   = {1'b0, sum_ff} + (ppa_pkg::SUM_W + 1)'(root_ff);
      scale_sum  = {1'b0, scale_x} + {1'b0, scale_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         if (state_ff == ST_EMIT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  last_ff     <= pop_job.last;
                  closing_ff  <= !pop_job.edge_valid;
                  close_dx_ff <= pop_job.close_dx;
                  close_dy_ff <= pop_job.close_dy;
                  dx_ff       <= pop_job.edge_valid ? pop_job.edge_dx : pop_job.close_dx;
                  dy_ff       <= pop_job.edge_valid ? pop_job.edge_dy : pop_job.close_dy;
                  if (pop_job.edge_valid || pop_job.last) begin
                     state_ff <= ST_SQUARE;
                  end
               end
            end
            ST_SQUARE: begin
               sqx_ff   <= ppa_pkg::SQUARE_W'(dx_ff) * ppa_pkg::SQUARE_W'(dx_ff);
               sqy_ff   <= ppa_pkg::SQUARE_W'(dy_ff) * ppa_pkg::SQUARE_W'(dy_ff);
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               rad_ff   <= {2'b00, sqx_ff} + {2'b00, sqy_ff};
               rem_ff   <= '0;
               root_ff  <= '0;
               iter_ff  <= '0;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               rad_ff  <= {rad_ff[ppa_pkg::RADICAND_W-3:0], 2'b00};
               rem_ff  <= root_ge ? rem_diff[ppa_pkg::REM_W-1:0]
                                  : rem_shift[ppa_pkg::REM_W-1:0];
               root_ff <= {root_ff[ppa_pkg::ROOT_W-2:0], root_ge};
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == ppa_pkg::ITER_W'(ppa_pkg::ROOT_ITERS - 1)) begin
                  state_ff <= ST_ACCUM;
               end
            end
            ST_ACCUM: begin
               // clip the running sum rather than wrap
               sum_ff <= sum_next[ppa_pkg::SUM_W] ? '1 : sum_next[ppa_pkg::SUM_W-1:0];
               if (last_ff && !closing_ff) begin
                  closing_ff <= 1'b1;
                  dx_ff      <= close_dx_ff;
                  dy_ff      <= close_dy_ff;
                  state_ff   <= ST_SQUARE;
               end else if (last_ff) begin
                  state_ff <= ST_MULT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_MULT: begin
               prod_ff  <= ppa_pkg::PROD_W'(sum_ff) * ppa_pkg::PROD_W'(scale_sum);
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  perim_ff     <= prod_ff[ppa_pkg::PERIM_W] ? '1
                                                            : prod_ff[ppa_pkg::PERIM_W-1:0];
                  sat_ff       <= prod_ff[ppa_pkg::PERIM_W];
                  sum_ff       <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: src/polygon_perimeter_accumulator_top.sv
`timescale 1ns / 1ps
// Closed polygon perimeter accumulator. Vertices arrive one per req_bus
// transfer in signed Q1.14; last_vertex closes the polygon and produces one
// rsp_bus transfer: sum of floor Euclidean edge lengths times
// (scale_x + scale_y), unsigned with 22 fraction bits, clipped to 2^48-1
// with saturated set. A vertex that opens a polygon without closing it only
// passes the back-end idle state; every other vertex goes through square,
// load, 17-step bit-serial square root and accumulate, and a closing vertex
// runs these for the closing edge, then the scale multiply and result load.
// The shared square-root unit in the back end limits the vertex rate; the
// front end keeps accepting into a QUEUE_DEPTH-entry queue while it works.
// Registers: scale_x at byte address 0, scale_y at 4, both reset to 10.0.
module polygon_perimeter_accumulator_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   ppa_req_if.sink                          req_bus,
   ppa_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ppa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ppa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ppa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   logic [ppa_pkg::SCALE_W-1:0]  scale_x_ff;
   logic [ppa_pkg::SCALE_W-1:0]  scale_y_ff;
   logic                         csr_write;
   ppa_pkg::csr_index_type       csr_index;
   logic                         push_valid;
   logic                         push_ready;
   ppa_pkg::edge_job_type        push_job;
   logic                         pop_valid;
   logic                         pop_ready;
   ppa_pkg::edge_job_type        pop_job;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = ppa_pkg::csr_index_type'(paddr[2]);

   always_comb begin
      unique case (csr_index)
         ppa_pkg::CSR_SCALE_X: prdata = {{(ppa_pkg::CSR_DATA_W-ppa_pkg::SCALE_W){1'b0}},
                                         scale_x_ff};
         ppa_pkg::CSR_SCALE_Y: prdata = {{(ppa_pkg::CSR_DATA_W-ppa_pkg::SCALE_W){1'b0}},
                                         scale_y_ff};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= ppa_pkg::SCALE_RESET;
         scale_y_ff <= ppa_pkg::SCALE_RESET;
      end else if (csr_write) begin
         if (csr_index == ppa_pkg::CSR_SCALE_X) begin
            scale_x_ff <= pwdata[ppa_pkg::SCALE_W-1:0];
         end else begin
            scale_y_ff <= pwdata[ppa_pkg::SCALE_W-1:0];
         end
      end
   end

   ppa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   ppa_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   ppa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .scale_x   (scale_x_ff),
      .scale_y   (scale_y_ff),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: src/ppa_checker.sv
`timescale 1ns / 1ps
module ppa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ppa_pkg::PERIM_W-1:0]      rsp_perimeter,
   input logic                             rsp_saturated,
   input logic                             psel,
   input logic                             penable,
   input logic                             pwrite,
   input logic [ppa_pkg::CSR_ADDR_W-1:0]   paddr,
   input logic [ppa_pkg::CSR_DATA_W-1:0]   pwdata,
   input logic [ppa_pkg::CSR_DATA_W-1:0]   prdata
);

   // hold a result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_perimeter))
      else $error("result dropped or changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_sat_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_perimeter == '1)
      else $error("saturated result not clipped to full range");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite) ##1 (psel && !pwrite && paddr[2] == $past(paddr[2]))
      |-> prdata == {{(ppa_pkg::CSR_DATA_W-ppa_pkg::SCALE_W){1'b0}},
                     $past(pwdata[ppa_pkg::SCALE_W-1:0])})
      else $error("scale register readback mismatch");

endmodule

bind polygon_perimeter_accumulator_top ppa_checker u_ppa_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_perimeter (rsp_bus.perimeter),
   .rsp_saturated (rsp_bus.saturated),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .paddr         (paddr),
   .pwdata        (pwdata),
   .prdata        (prdata)
);

FILE: bench/ppa_perimeter_check.sv
`timescale 1ns / 1ps
module ppa_perimeter_check (
   input  logic                           clock,
   input  logic                           reset,
   ppa_req_if                             req_mon,
   ppa_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [ppa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ppa_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             fail_count,
   output int                             pending_results,
   output int                             vertex_count,
   output int                             perimeter_count,
   output int                             clipped_count
);

   typedef struct packed {
      logic [ppa_pkg::PERIM_W-1:0] perimeter;
      logic                        saturated;
   } perimeter_result_type;

   perimeter_result_type expected_perimeters[$];

   logic [ppa_pkg::SCALE_W-1:0]        scale_x_q;
   logic [ppa_pkg::SCALE_W-1:0]        scale_y_q;
   logic signed [ppa_pkg::COORD_W-1:0] first_x_q;
   logic signed [ppa_pkg::COORD_W-1:0] first_y_q;
   logic signed [ppa_pkg::COORD_W-1:0] prev_x_q;
   logic signed [ppa_pkg::COORD_W-1:0] prev_y_q;
   logic [ppa_pkg::SUM_W-1:0]          length_sum_q;
   logic                               polygon_open_q;

   initial begin
      fail_count      = 0;
      pending_results = 0;
      vertex_count    = 0;
      perimeter_count = 0;
      clipped_count   = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // bit by bit from the top: keep a root bit if its square still fits
   function automatic logic [ppa_pkg::ROOT_W:0] floor_sqrt(input logic [35:0] radicand);
      logic [ppa_pkg::ROOT_W:0] root;
      logic [ppa_pkg::ROOT_W:0] trial;
      root = '0;
      for (int b = ppa_pkg::ROOT_W; b >= 0; b--) begin
         trial = root | ((ppa_pkg::ROOT_W + 1)'(1) << b);
         if (36'(trial) * 36'(trial) <= radicand)
            root = trial;
      end
      return root;
   endfunction

   function automatic logic [ppa_pkg::ROOT_W:0] edge_length(
         input logic signed [ppa_pkg::COORD_W-1:0] ax,
         input logic signed [ppa_pkg::COORD_W-1:0] ay,
         input logic signed [ppa_pkg::COORD_W-1:0] bx,
         input logic signed [ppa_pkg::COORD_W-1:0] by);
      int          dx;
      int          dy;
      logic [35:0] dist_sq;
      dx = int'(ax) - int'(bx);
      dy = int'(ay) - int'(by);
      if (dx < 0)
         dx = -dx;
      if (dy < 0)
         dy = -dy;
      dist_sq = 36'(dx) * 36'(dx) + 36'(dy) * 36'(dy);
      return floor_sqrt(dist_sq);
   endfunction

   // hold the sum at full range instead of wrapping
   function automatic logic [ppa_pkg::SUM_W-1:0] add_clipped(
         input logic [ppa_pkg::SUM_W-1:0] sum,
         input logic [ppa_pkg::ROOT_W:0]  len);
      logic [ppa_pkg::SUM_W:0] wide;
      wide = {1'b0, sum} + (ppa_pkg::SUM_W + 1)'(len);
      return wide[ppa_pkg::SUM_W] ? {ppa_pkg::SUM_W{1'b1}} : wide[ppa_pkg::SUM_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      perimeter_result_type               got;
      perimeter_result_type               want;
      logic signed [ppa_pkg::COORD_W-1:0] vx;
      logic signed [ppa_pkg::COORD_W-1:0] vy;
      logic [ppa_pkg::SCALE_SUM_W-1:0]    scale_sum;
      logic [ppa_pkg::PROD_W-1:0]         product;
      if (reset) begin
         expected_perimeters.delete();
         scale_x_q      = ppa_pkg::SCALE_RESET;
         scale_y_q      = ppa_pkg::SCALE_RESET;
         first_x_q      = '0;
         first_y_q      = '0;
         prev_x_q       = '0;
         prev_y_q       = '0;
         length_sum_q   = '0;
         polygon_open_q = 1'b0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ppa_pkg::CSR_ADDR_W'({ppa_pkg::CSR_SCALE_X, 2'b00}))
               scale_x_q = pwdata[ppa_pkg::SCALE_W-1:0];
            else if (paddr == ppa_pkg::CSR_ADDR_W'({ppa_pkg::CSR_SCALE_Y, 2'b00}))
               scale_y_q = pwdata[ppa_pkg::SCALE_W-1:0];
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.perimeter = rsp_mon.perimeter;
            got.saturated = rsp_mon.saturated;
            perimeter_count++;
            if (got.saturated === 1'b1)
               clipped_count++;
            if (expected_perimeters.size() == 0) begin
               report_mismatch($sformatf("perimeter %0d with no polygon closed",
                                         got.perimeter));
            end else begin
               want = expected_perimeters.pop_front();
               if (got.perimeter !== want.perimeter)
                  report_mismatch($sformatf("perimeter %0d, predicted %0d",
                                            got.perimeter, want.perimeter));
               if (got.saturated !== want.saturated)
                  report_mismatch($sformatf("saturated %b, predicted %b (perimeter %0d)",
                                            got.saturated, want.saturated, want.perimeter));
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            vx = req_mon.vertex_x;
            vy = req_mon.vertex_y;
            vertex_count++;
            if (!polygon_open_q) begin
               first_x_q      = vx;
               first_y_q      = vy;
               length_sum_q   = '0;
               polygon_open_q = 1'b1;
            end else begin
               length_sum_q = add_clipped(length_sum_q, edge_length(vx, vy, prev_x_q, prev_y_q));
            end
            prev_x_q = vx;
            prev_y_q = vy;
            if (req_mon.last_vertex) begin
               // close the polygon back to its first vertex, then scale
               length_sum_q = add_clipped(length_sum_q,
                                          edge_length(first_x_q, first_y_q, vx, vy));
               scale_sum = {1'b0, scale_x_q} + {1'b0, scale_y_q};
               product   = ppa_pkg::PROD_W'(length_sum_q) * ppa_pkg::PROD_W'(scale_sum);
               want.saturated = product[ppa_pkg::PERIM_W];
               want.perimeter = product[ppa_pkg::PERIM_W] ? {ppa_pkg::PERIM_W{1'b1}}
                                                          : product[ppa_pkg::PERIM_W-1:0];
               expected_perimeters.push_back(want);
               polygon_open_q = 1'b0;
               length_sum_q   = '0;
            end
         end
      end
      pending_results <= expected_perimeters.size();
   end

endmodule

FILE: bench/tb_polygon_perimeter_accumulator_top.sv
`timescale 1ns / 1ps
module tb_polygon_perimeter_accumulator_top;

   localparam int SETTLE_CYCLES         = 80;
   localparam int HOLD_OFF_CYCLES       = 400;
   localparam int RANDOM_PHASES         = 6;
   localparam int PHASE_VERTICES        = 120;
   localparam int LONG_POLYGON_VERTICES = 64;

   localparam logic signed [ppa_pkg::COORD_W-1:0] COORD_MIN = 16'sh8000;
   localparam logic signed [ppa_pkg::COORD_W-1:0] COORD_MAX = 16'sh7FFF;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic                           pready;
   logic [ppa_pkg::CSR_ADDR_W-1:0] paddr;
   logic [ppa_pkg::CSR_DATA_W-1:0] pwdata;
   logic [ppa_pkg::CSR_DATA_W-1:0] prdata;

   int fail_count;
   int pending_results;
   int vertex_count;
   int perimeter_count;
   int clipped_count;

   int hold_offs_asked  = 0;
   int hold_offs_served = 0;
   int scale_writes     = 0;
   int vertices_sent    = 0;
   int stall_left       = 0;
   int mode_left        = 0;
   bit rsp_calm         = 1'b0;

   logic signed [ppa_pkg::COORD_W-1:0] prev_x = '0;
   logic signed [ppa_pkg::COORD_W-1:0] prev_y = '0;

   ppa_req_if req_bus ();
   ppa_rsp_if rsp_bus ();

   polygon_perimeter_accumulator_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   ppa_perimeter_check perimeter_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .vertex_count    (vertex_count),
      .perimeter_count (perimeter_count),
      .clipped_count   (clipped_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results outstanding", pending_results);
      $display("simulation failed");
      $finish;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic logic signed [ppa_pkg::COORD_W-1:0] rand_coord(
         input logic signed [ppa_pkg::COORD_W-1:0] near);
      int roll;
      roll = $urandom_range(0, 9);
      case (roll) inside
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         [2:3]:   return ppa_pkg::COORD_W'($urandom_range(0, 8)) - 16'sd4;
         [4:5]:   return near + ppa_pkg::COORD_W'($urandom_range(0, 32)) - 16'sd16;
         default: return ppa_pkg::COORD_W'($urandom);
      endcase
   endfunction

   // result side: random stalls, calm stretches, and long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (hold_offs_asked != hold_offs_served) begin
         rsp_bus.ready <= 1'b0;
         stall_left = HOLD_OFF_CYCLES - 1;
         hold_offs_served++;
      end else begin
         if (mode_left == 0) begin
            rsp_calm  = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         stall_left = rsp_calm ? 0 : pick_gap();
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_vertex(input logic signed [ppa_pkg::COORD_W-1:0] x,
                              input logic signed [ppa_pkg::COORD_W-1:0] y,
                              input logic final_vertex,
                              input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.vertex_x    <= x;
      req_bus.vertex_y    <= y;
      req_bus.last_vertex <= final_vertex;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      prev_x = x;
      prev_y = y;
      vertices_sent++;
   endtask

   task automatic send_polygon(input int count, input bit calm);
      for (int i = 0; i < count; i++)
         send_vertex(rand_coord(prev_x), rand_coord(prev_y), i == count - 1,
                     calm ? 0 : pick_gap());
   endtask

   // stop offering, wait out every perimeter, then let the back end go quiet
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input ppa_pkg::csr_index_type idx,
                              input logic [ppa_pkg::SCALE_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ppa_pkg::CSR_ADDR_W'({idx, 2'b00});
      // junk in the upper bits must be dropped by the register
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      scale_writes++;
   endtask

   task automatic set_scales(input logic [ppa_pkg::SCALE_W-1:0] sx,
                             input logic [ppa_pkg::SCALE_W-1:0] sy);
      write_scale(ppa_pkg::CSR_SCALE_X, sx);
      write_scale(ppa_pkg::CSR_SCALE_Y, sy);
   endtask

   initial begin
      int phase_start;
      int roll;
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.vertex_x    = '0;
      req_bus.vertex_y    = '0;
      req_bus.last_vertex = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-vertex polygons close with a zero edge
      send_vertex('0, '0, 1'b1, 0);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1, 0);
      // corners of the full range
      send_vertex(COORD_MIN, COORD_MIN, 1'b0, 0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0, 1);
      send_vertex(COORD_MAX, COORD_MAX, 1'b0, 0);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1, 2);
      // longest possible edge
      send_vertex(COORD_MIN, COORD_MIN, 1'b0, 0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b1, 0);
      // square root truncation on tiny edges
      send_vertex(16'sd0, 16'sd0, 1'b0, 0);
      send_vertex(16'sd1, 16'sd1, 1'b0, 0);
      send_vertex(16'sd0, 16'sd1, 1'b1, 0);
      // repeated point
      send_vertex(16'sh1234, -16'sh1234, 1'b0, 0);
      send_vertex(16'sh1234, -16'sh1234, 1'b1, 0);
      send_vertex(16'sh5555, 16'shAAAA, 1'b0, 3);
      send_vertex(16'shAAAA, 16'sh5555, 1'b1, 0);
      drain();

      // zero scales give zero perimeter
      set_scales(16'h0000, 16'h0000);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0, 0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0, 0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b1, 0);
      drain();
      set_scales(16'hFFFF, 16'hFFFF);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0, 0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0, 0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b0, 0);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1, 0);
      drain();
      set_scales(16'hFFFF, 16'h0000);
      send_vertex(COORD_MAX, 16'sd0, 1'b0, 0);
      send_vertex(COORD_MIN, 16'sd0, 1'b1, 0);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       set_scales(16'h0001, 16'h0000);
            1:       set_scales(16'h0000, 16'hFFFF);
            2:       set_scales(16'h0A00, 16'h0A00);
            3:       set_scales(16'hFFFF, 16'hFFFF);
            default: set_scales(16'($urandom), 16'($urandom));
         endcase
         phase_start = vertices_sent;
         while (vertices_sent - phase_start < PHASE_VERTICES) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
               send_polygon($urandom_range(1, 3), $urandom_range(0, 4) == 0);
            else if (roll < 85)
               send_polygon($urandom_range(4, 10), $urandom_range(0, 4) == 0);
            else if (roll < 95)
               send_polygon($urandom_range(11, 40), $urandom_range(0, 2) == 0);
            else
               drain();
         end
         drain();
      end

      // hold the result side while single-vertex polygons keep coming
      hold_offs_asked <= hold_offs_asked + 1;
      for (int i = 0; i < 16; i++)
         send_vertex(rand_coord(prev_x), rand_coord(prev_y), 1'b1, 0);
      drain();

      // a longer polygon of full-length edges at the largest scales
      set_scales(16'hFFFF, 16'hFFFF);
      for (int i = 0; i < LONG_POLYGON_VERTICES; i++)
         send_vertex(i % 2 ? COORD_MAX : COORD_MIN, i % 2 ? COORD_MAX : COORD_MIN,
                     i == LONG_POLYGON_VERTICES - 1, 0);
      drain();

      $display("checked %0d vertices and %0d perimeters over %0d scale register writes",
               vertex_count, perimeter_count, scale_writes);
      $display("%0d perimeters clipped, one polygon of %0d vertices, %0d result hold-offs",
               clipped_count, LONG_POLYGON_VERTICES, hold_offs_served);
      if (fail_count == 0 && pending_results == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
